FILE: hdl/lgrs_pkg.sv
// Shared types and constants for the Life row stencil block.
// No dependencies.
`timescale 1ns / 1ps

package lgrs_pkg;

  localparam int ROW_W       = 64;
  localparam int IDX_W       = 12;
  localparam int WID_W       = 7;
  localparam int HGT_W       = 13;
  localparam int CFG_W       = 13;
  localparam int OUT_TDATA_W = 80;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;
  localparam int CNT_W       = 4;

  localparam logic [WID_W-1:0] MIN_WIDTH    = 7'd3;
  localparam logic [WID_W-1:0] RESET_WIDTH  = 7'd33;
  localparam logic [HGT_W-1:0] MIN_HEIGHT   = 13'd3;
  localparam logic [HGT_W-1:0] MAX_HEIGHT   = 13'd4096;
  localparam logic [HGT_W-1:0] RESET_HEIGHT = 13'd33;

  localparam logic [CNT_W-1:0] BIRTH_COUNT = 4'd3;
  localparam logic [CNT_W-1:0] KEEP_COUNT  = 4'd2;

  typedef enum logic [0:0] {
    CFG_GRID_WIDTH  = 1'b0,
    CFG_GRID_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic advance;
    logic restart;
    logic flush;
    logic second_row;
  } cell_ctl_t;

  typedef struct packed {
    logic up;
    logic mid;
    logic dn;
  } cell_taps_t;

  typedef struct packed {
    logic [ROW_W-1:0] bits;
    logic [IDX_W-1:0] index;
    logic             last;
  } out_item_t;

endpackage

FILE: hdl/lgrs_cell.sv
// One column cell: holds two stored row bits and computes the next-generation bit.
// Depends on lgrs_pkg.
`timescale 1ns / 1ps

module lgrs_cell #(
  parameter int COL = 0
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  lgrs_pkg::cell_ctl_t       ctl_i,
  input  logic [lgrs_pkg::WID_W-1:0] width_i,
  input  logic                      row_bit_i,
  input  lgrs_pkg::cell_taps_t      left_i,
  input  lgrs_pkg::cell_taps_t      right_i,
  output lgrs_pkg::cell_taps_t      taps_o,
  output logic                      next_bit_o
);
  import lgrs_pkg::*;

  localparam logic [WID_W-1:0] ColIdx  = WID_W'(COL);
  localparam logic [WID_W-1:0] ColNext = WID_W'(COL + 1);

  logic             older_q, older_d;
  logic             middle_q, middle_d;
  logic             col_en;
  logic             interior;
  logic [CNT_W-1:0] nbr_cnt;
  logic             rule_bit;

  assign col_en   = ColIdx < width_i;
  assign interior = (COL >= 1) && (ColNext < width_i);

  assign taps_o.up  = older_q & col_en;
  assign taps_o.mid = middle_q & col_en;
  assign taps_o.dn  = row_bit_i & col_en;

  always_comb begin
    nbr_cnt = CNT_W'(left_i.up) + CNT_W'(taps_o.up) + CNT_W'(right_i.up)
            + CNT_W'(left_i.mid) + CNT_W'(right_i.mid)
            + CNT_W'(left_i.dn) + CNT_W'(taps_o.dn) + CNT_W'(right_i.dn);
    if (nbr_cnt == BIRTH_COUNT) begin
      rule_bit = 1'b1;
    end else if (nbr_cnt == KEEP_COUNT) begin
      rule_bit = taps_o.mid;
    end else begin
      rule_bit = 1'b0;
    end
  end

  assign next_bit_o = (interior && !ctl_i.second_row) ? rule_bit : taps_o.mid;

  always_comb begin
    older_d  = older_q;
    middle_d = middle_q;
    if (ctl_i.advance) begin
      if (ctl_i.restart) begin
        older_d  = 1'b0;
        middle_d = taps_o.dn;
      end else if (ctl_i.flush) begin
        older_d  = 1'b0;
        middle_d = 1'b0;
      end else begin
        older_d  = middle_q;
        middle_d = taps_o.dn;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      older_q  <= 1'b0;
      middle_q <= 1'b0;
    end else begin
      older_q  <= older_d;
      middle_q <= middle_d;
    end
  end

endmodule

FILE: hdl/lgrs_out_queue.sv
// Result queue: takes up to two results per cycle, hands out one per transaction.
// Depends on lgrs_pkg.
`timescale 1ns / 1ps

module lgrs_out_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push0_i,
  input  logic                push1_i,
  input  lgrs_pkg::out_item_t item0_i,
  input  lgrs_pkg::out_item_t item1_i,
  output logic                space_o,
  output logic                valid_o,
  input  logic                pop_i,
  output lgrs_pkg::out_item_t item_o
);
  import lgrs_pkg::*;

  out_item_t         mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;
  logic              do_pop;

  assign valid_o = count_q != '0;
  assign space_o = count_q <= QCNT_W'(QUEUE_DEPTH - 2);
  assign item_o  = mem_q[rd_ptr_q];
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q + QPTR_W'(push0_i) + QPTR_W'(push1_i);
    rd_ptr_d = rd_ptr_q + QPTR_W'(do_pop);
    count_d  = count_q + QCNT_W'(push0_i) + QCNT_W'(push1_i) - QCNT_W'(do_pop);
  end

  always_ff @(posedge clk_i) begin
    if (push0_i) begin
      mem_q[wr_ptr_q] <= item0_i;
    end
    if (push1_i) begin
      mem_q[wr_ptr_q + QPTR_W'(1)] <= item1_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

FILE: hdl/life_generation_row_stencil_top.sv
// Life B3/S23 row stencil: rows in, next-generation rows out, fixed border.
// A row's result is written into the result queue when the frame's following row is accepted.
// Throughput: one row per cycle while the result queue has space; the column cells update in parallel in one step.
// The last row of a frame gives two results through a four-entry result queue.
// Reset: width and height return to 33, stored rows and row counter clear, queue empties.
// Depends on lgrs_pkg, lgrs_cell, lgrs_out_queue.
`timescale 1ns / 1ps

module life_generation_row_stencil_top #(
  parameter int MAX_WIDTH = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  lgrs_pkg::cfg_reg_e                  cfg_idx_i,
  input  logic [lgrs_pkg::CFG_W-1:0]          cfg_wdata_i,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [lgrs_pkg::ROW_W-1:0]          s_axis_tdata,  // [63:0] row_bits
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [lgrs_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,  // [63:0] next_row_bits,
                                                             // [75:64] row_index, [79:76] zero
  output logic                                m_axis_tlast   // last_row
);
  import lgrs_pkg::*;

  localparam logic [WID_W-1:0] MaxW = WID_W'(MAX_WIDTH);

  logic [WID_W-1:0] width_q;
  logic [HGT_W-1:0] height_q;
  logic [IDX_W-1:0] row_cnt_q, row_cnt_d;
  logic [WID_W-1:0] width_eff;
  logic [HGT_W-1:0] height_eff;
  logic             in_acc;
  logic             at_first;
  logic             at_last;
  cell_ctl_t        cell_ctl;
  cell_taps_t       taps [MAX_WIDTH];
  logic [ROW_W-1:0] next_row;
  logic [ROW_W-1:0] row_masked;
  out_item_t        item0, item1, head;
  logic             q_space;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= RESET_WIDTH;
      height_q <= RESET_HEIGHT;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_GRID_WIDTH:  width_q  <= cfg_wdata_i[WID_W-1:0];
        CFG_GRID_HEIGHT: height_q <= cfg_wdata_i[HGT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (width_q < MIN_WIDTH) begin
      width_eff = MIN_WIDTH;
    end else if (width_q > MaxW) begin
      width_eff = MaxW;
    end else begin
      width_eff = width_q;
    end
    if (height_q < MIN_HEIGHT) begin
      height_eff = MIN_HEIGHT;
    end else if (height_q > MAX_HEIGHT) begin
      height_eff = MAX_HEIGHT;
    end else begin
      height_eff = height_q;
    end
  end

  assign s_axis_tready = q_space;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign at_first      = row_cnt_q == '0;
  assign at_last       = {1'b0, row_cnt_q} >= (height_eff - HGT_W'(1));

  assign cell_ctl.advance    = in_acc;
  assign cell_ctl.restart    = at_first;
  assign cell_ctl.flush      = at_last;
  assign cell_ctl.second_row = row_cnt_q == IDX_W'(1);

  always_comb begin
    row_cnt_d = row_cnt_q;
    if (in_acc) begin
      if (at_first) begin
        row_cnt_d = IDX_W'(1);
      end else if (at_last) begin
        row_cnt_d = '0;
      end else begin
        row_cnt_d = row_cnt_q + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_cnt_q <= '0;
    end else begin
      row_cnt_q <= row_cnt_d;
    end
  end

  for (genvar c = 0; c < ROW_W; c++) begin : g_col
    if (c < MAX_WIDTH) begin : g_cell
      cell_taps_t left_taps, right_taps;
      if (c == 0) begin : g_lft_edge
        assign left_taps = '0;
      end else begin : g_lft
        assign left_taps = taps[c-1];
      end
      if (c == MAX_WIDTH - 1) begin : g_rgt_edge
        assign right_taps = '0;
      end else begin : g_rgt
        assign right_taps = taps[c+1];
      end
      lgrs_cell #(
        .COL(c)
      ) u_cell (
        .clk_i      (clk_i),
        .rst_ni     (rst_ni),
        .ctl_i      (cell_ctl),
        .width_i    (width_eff),
        .row_bit_i  (s_axis_tdata[c]),
        .left_i     (left_taps),
        .right_i    (right_taps),
        .taps_o     (taps[c]),
        .next_bit_o (next_row[c])
      );
      assign row_masked[c] = taps[c].dn;
    end else begin : g_unused
      assign next_row[c]   = 1'b0;
      assign row_masked[c] = 1'b0;
    end
  end

  assign item0.bits  = next_row;
  assign item0.index = row_cnt_q - IDX_W'(1);
  assign item0.last  = 1'b0;
  assign item1.bits  = row_masked;
  assign item1.index = row_cnt_q;
  assign item1.last  = 1'b1;

  lgrs_out_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push0_i (in_acc && !at_first),
    .push1_i (in_acc && !at_first && at_last),
    .item0_i (item0),
    .item1_i (item1),
    .space_o (q_space),
    .valid_o (m_axis_tvalid),
    .pop_i   (m_axis_tready),
    .item_o  (head)
  );

  assign m_axis_tdata = {(OUT_TDATA_W - ROW_W - IDX_W)'(0), head.index, head.bits};
  assign m_axis_tlast = head.last;

endmodule
